/* sv/srfp_pkg.sv */
// Shared types and constants for the servo reply frame parser.
// No dependencies; imported by the frame tracker, the top level and the testbench.
package srfp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned CFG_ADDR_W = 4;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hFF;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h69;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SERVO_ID = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_REG_ADDR = 4'd1;

    localparam logic [BYTE_W-1:0] MAX_SERVO_ID_RST = 8'd6;
    localparam logic [BYTE_W-1:0] MAX_REG_ADDR_RST = 8'hC2;

    // One decoded frame as handed from the tracker to the output register
    typedef struct packed {
        logic                valid;
        logic [BYTE_W-1:0]   servo_id;
        logic [BYTE_W-1:0]   reg_addr;
        logic [VALUE_W-1:0]  reg_value;
        logic                in_range;
    } frame_out_t;

endpackage

/* sv/srfp_frame_fsm.sv */
// Frame tracker: header hunt, body capture and additive checksum check.
// Depends on srfp_pkg; advances one byte per accepted item.
module srfp_frame_fsm
    import srfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] max_servo_id,
    input  logic [BYTE_W-1:0] max_reg_addr,
    output frame_out_t        frame
);

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_HDR2 = 4'd1,
        PH_ID   = 4'd2,
        PH_ADDR = 4'd3,
        PH_LEN  = 4'd4,
        PH_LOW  = 4'd5,
        PH_HIGH = 4'd6,
        PH_CSUM = 4'd7
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] held_id_reg,   held_id_next;
    logic [BYTE_W-1:0] held_addr_reg, held_addr_next;
    logic [BYTE_W-1:0] held_low_reg,  held_low_next;
    logic [BYTE_W-1:0] held_high_reg, held_high_next;
    logic [BYTE_W-1:0] sum_reg,       sum_next;

    always_comb begin
        phase_next     = phase_reg;
        held_id_next   = held_id_reg;
        held_addr_next = held_addr_reg;
        held_low_next  = held_low_reg;
        held_high_next = held_high_reg;
        sum_next       = sum_reg + rx_byte;
        unique case (phase_reg)
            PH_HDR2: phase_next = (rx_byte == HDR_SECOND) ? PH_ID : PH_HUNT;
            PH_ID: begin
                held_id_next = rx_byte;
                sum_next     = rx_byte;
                phase_next   = PH_ADDR;
            end
            PH_ADDR: begin
                held_addr_next = rx_byte;
                phase_next     = PH_LEN;
            end
            PH_LEN:  phase_next = PH_LOW;
            PH_LOW: begin
                held_low_next = rx_byte;
                phase_next    = PH_HIGH;
            end
            PH_HIGH: begin
                held_high_next = rx_byte;
                phase_next     = PH_CSUM;
            end
            PH_CSUM: phase_next = PH_HUNT;
            // Unreachable codes behave like hunting
            default: phase_next = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
        endcase
    end

    always_comb begin
        frame.valid     = byte_accept && (phase_reg == PH_CSUM) && (rx_byte == sum_reg);
        frame.servo_id  = held_id_reg;
        frame.reg_addr  = held_addr_reg;
        frame.reg_value = {held_high_reg, held_low_reg};
        frame.in_range  = (held_id_reg != '0) && (held_id_reg <= max_servo_id)
                          && (held_addr_reg <= max_reg_addr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else if (byte_accept) begin
            phase_reg <= phase_next;
        end
        if (byte_accept) begin
            held_id_reg   <= held_id_next;
            held_addr_reg <= held_addr_next;
            held_low_reg  <= held_low_next;
            held_high_reg <= held_high_next;
            sum_reg       <= sum_next;
        end
    end

endmodule

/* sv/servo_reply_frame_parser.sv */
// Top level of the servo reply frame parser: config registers, stream ports
// and the result register. Depends on srfp_pkg and srfp_frame_fsm.

// Accepts one received byte per cycle and finds frames of the form 0xFF 0x69,
// id, address, length, data low, data high, checksum. A frame whose checksum
// equals the low byte of the sum of its five body bytes yields one result on
// the master side in the cycle after its checksum byte is accepted; bad frames
// yield nothing. The sustained rate is one byte per cycle: the frame tracker
// handles each byte in the cycle it is accepted, and s_tready drops only while
// a finished result sits in the output register with m_tready low.
module servo_reply_frame_parser
    import srfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [BYTE_W-1:0]     cfg_wdata,
    // received bytes
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    // decoded frames
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [7:0] servo_id, [15:8] reg_addr,
                                             // [31:16] reg_value
    output logic [0:0]            m_tuser    // [0] in_range
);

    logic [BYTE_W-1:0] max_servo_id_reg;
    logic [BYTE_W-1:0] max_reg_addr_reg;
    logic              out_valid_reg;
    frame_out_t        out_reg;
    frame_out_t        frame;
    logic              byte_accept;

    assign s_tready    = !out_valid_reg || m_tready;
    assign byte_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_servo_id_reg <= MAX_SERVO_ID_RST;
            max_reg_addr_reg <= MAX_REG_ADDR_RST;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_MAX_SERVO_ID) begin
                max_servo_id_reg <= cfg_wdata;
            end else if (cfg_addr == CFG_MAX_REG_ADDR) begin
                max_reg_addr_reg <= cfg_wdata;
            end
        end
    end

    srfp_frame_fsm u_fsm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .rx_byte      (s_tdata),
        .max_servo_id (max_servo_id_reg),
        .max_reg_addr (max_reg_addr_reg),
        .frame        (frame)
    );

    // Update the valid flag whenever the register is free; only a good
    // checksum marks it valid and loads the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= frame.valid;
        end
        if (frame.valid) begin
            out_reg <= frame;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.reg_value, out_reg.reg_addr, out_reg.servo_id};
    assign m_tuser  = out_reg.in_range;

endmodule

/* sv/srfp_checker.sv */
// Port-level checks for the servo reply frame parser, bound to the top level.
// Depends on the servo_reply_frame_parser port list.
module srfp_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [31:0]           m_tdata,
    input logic [0:0]            m_tuser
);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input side stalls only behind a waiting result
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with free output register");

    // a new result only follows an accepted item
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(m_tvalid && !m_tready) |-> $past(s_tvalid && s_tready))
        else $error("result without accepted item");

    // servo id zero is never in range
    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[7:0] == 8'd0) |-> !m_tuser[0])
        else $error("id zero flagged in range");

endmodule

bind servo_reply_frame_parser srfp_checker u_srfp_checker (.*);

/* sim/servo_reply_frame_parser_tb.sv */
// Self-checking testbench for servo_reply_frame_parser: streams received bytes,
// predicts decoded frames and compares them item by item.
// Depends on srfp_pkg and the servo_reply_frame_parser RTL.
module servo_reply_frame_parser_tb;
    import srfp_pkg::*;

    localparam int unsigned TICK          = 8;
    localparam int unsigned RANDOM_ITEMS  = 840;
    localparam int unsigned MAX_GAP       = 16;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES  = 5000;
    localparam int unsigned RUN_CYCLES    = 500000;

    // indexes with no register behind them
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_IDX = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOP_IDX   = 4'd15;

    typedef enum logic [3:0] {
        SEEK_SYNC, SEEK_TAG, TAKE_ID, TAKE_ADDR, TAKE_LEN, TAKE_LOW, TAKE_HIGH, TAKE_SUM
    } rx_phase_t;

    typedef struct {
        logic [BYTE_W-1:0]  servo_id;
        logic [BYTE_W-1:0]  reg_addr;
        logic [VALUE_W-1:0] reg_value;
        logic               in_range;
    } reply_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [BYTE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] rx_byte
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;          // [7:0] servo_id, [15:8] reg_addr, [31:16] reg_value
    logic [0:0]            m_tuser;          // [0] in_range

    // frame tracker copy and register copy
    rx_phase_t         rx_phase   = SEEK_SYNC;
    logic [BYTE_W-1:0] hold_id    = '0;
    logic [BYTE_W-1:0] hold_addr  = '0;
    logic [BYTE_W-1:0] hold_low   = '0;
    logic [BYTE_W-1:0] hold_high  = '0;
    logic [BYTE_W-1:0] body_sum   = '0;
    logic [BYTE_W-1:0] id_limit   = MAX_SERVO_ID_RST;
    logic [BYTE_W-1:0] addr_limit = MAX_REG_ADDR_RST;

    reply_t      frames_due[$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;
    int unsigned hold_req       = 0;
    bit          send_idle      = 1'b1;
    bit          recv_idle      = 1'b1;

    servo_reply_frame_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #(TICK / 2) aclk = ~aclk;
    end

    initial begin
        #(TICK * RUN_CYCLES);
        $display("servo_reply_frame_parser verification failed");
        $finish;
    end

    // Advance the frame tracker by one accepted byte; queue a reply on a good checksum.
    function automatic void track_rx_byte(input logic [BYTE_W-1:0] b);
        reply_t r;
        case (rx_phase)
            SEEK_TAG:  rx_phase = (b == HDR_SECOND) ? TAKE_ID : SEEK_SYNC;
            TAKE_ID: begin
                hold_id  = b;
                body_sum = b;
                rx_phase = TAKE_ADDR;
            end
            TAKE_ADDR: begin
                hold_addr = b;
                body_sum  = body_sum + b;
                rx_phase  = TAKE_LEN;
            end
            TAKE_LEN: begin
                body_sum = body_sum + b;
                rx_phase = TAKE_LOW;
            end
            TAKE_LOW: begin
                hold_low = b;
                body_sum = body_sum + b;
                rx_phase = TAKE_HIGH;
            end
            TAKE_HIGH: begin
                hold_high = b;
                body_sum  = body_sum + b;
                rx_phase  = TAKE_SUM;
            end
            TAKE_SUM: begin
                if (b == body_sum) begin
                    r.servo_id  = hold_id;
                    r.reg_addr  = hold_addr;
                    r.reg_value = {hold_high, hold_low};
                    r.in_range  = (hold_id >= 8'd1) && (hold_id <= id_limit) &&
                                  (hold_addr <= addr_limit);
                    frames_due.push_back(r);
                end
                rx_phase = SEEK_SYNC;
            end
            default:   rx_phase = (b == HDR_FIRST) ? SEEK_TAG : SEEK_SYNC;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        track_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] id, addr, len, lo, hi,
                              input bit spoil);
        logic [BYTE_W-1:0] sum;
        sum = id + addr + len + lo + hi;
        if (spoil)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(id);
        send_byte(addr);
        send_byte(len);
        send_byte(lo);
        send_byte(hi);
        send_byte(sum);
    endtask

    // Bias toward the in-range boundaries around a limit.
    function automatic logic [BYTE_W-1:0] pick_edge(input logic [BYTE_W-1:0] lim);
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return lim - 8'd1;
            3:       return lim;
            4:       return lim + 8'd1;
            5:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_frame(input bit spoil);
        send_frame(pick_edge(id_limit), pick_edge(addr_limit), 8'($urandom),
                   8'($urandom), 8'($urandom), spoil);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [BYTE_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_SERVO_ID: id_limit   = val;
            CFG_MAX_REG_ADDR: addr_limit = val;
            default: ;
        endcase
    endtask

    // Drop valid, wait for every queued reply, then let the pipeline empty.
    task automatic settle_idle();
        int unsigned n;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        n = 0;
        while (frames_due.size() != 0 && n < DRAIN_CYCLES) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_directed_frames();
        send_frame(8'h01, MAX_REG_ADDR_RST, 8'h02, 8'h34, 8'h12, 1'b0);
        // a second 0xFF is a wrong tag byte and gets dropped, not re-examined
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_frame(MAX_SERVO_ID_RST, MAX_REG_ADDR_RST + 8'd1, 8'h00, 8'h00, 8'h00, 1'b1);
        settle_idle();
    endtask

    task automatic test_config_limits();
        logic [BYTE_W-1:0] id_set[6]   = '{8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'h06};
        logic [BYTE_W-1:0] addr_set[6] = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hC2};
        for (int i = 0; i < 6; i++) begin
            write_reg(CFG_MAX_SERVO_ID, id_set[i]);
            write_reg(CFG_MAX_REG_ADDR, addr_set[i]);
            // writes to unused indexes must leave both limits alone
            write_reg((i % 2) ? CFG_TOP_IDX : CFG_SPARE_IDX, 8'($urandom));
            send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
            for (int k = 0; k < 5; k++)
                send_random_frame($urandom_range(0, 5) == 0);
            settle_idle();
        end
    endtask

    task automatic test_output_backpressure();
        send_idle = 1'b0;
        hold_req  = LONG_HOLD;
        for (int k = 0; k < 6; k++)
            send_random_frame(1'b0);
        settle_idle();
        send_idle = 1'b1;
    endtask

    task automatic test_random_stream();
        int unsigned start;
        int unsigned next_cfg;
        int unsigned kind;
        start    = bytes_sent;
        next_cfg = start + 300;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            if (bytes_sent >= next_cfg) begin
                settle_idle();
                write_reg(CFG_MAX_SERVO_ID, ($urandom_range(0, 3) == 0) ?
                          8'($urandom_range(0, 1) * 8'hFF) : 8'($urandom));
                write_reg(CFG_MAX_REG_ADDR, ($urandom_range(0, 3) == 0) ?
                          8'($urandom_range(0, 1) * 8'hFF) : 8'($urandom));
                next_cfg = bytes_sent + 300;
            end
            if ($urandom_range(0, 31) == 0) send_idle = ~send_idle;
            if ($urandom_range(0, 31) == 0) recv_idle = ~recv_idle;
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_random_frame($urandom_range(0, 6) == 0);
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else if (kind < 88) begin
                // header start followed by a wrong tag byte
                send_byte(HDR_FIRST);
                send_byte($urandom_range(0, 1) ? HDR_FIRST : (8'($urandom) ^ HDR_SECOND) |
                          8'h01);
            end else if (kind < 96) begin
                // cut-short frame; the next bytes fill the remaining slots
                send_byte(HDR_FIRST);
                send_byte(HDR_SECOND);
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end else begin
                send_byte($urandom_range(0, 1) ? HDR_SECOND : HDR_FIRST);
            end
        end
        settle_idle();
    endtask

    // Receiver: hold m_tready low for a drawn number of cycles after each item.
    initial begin
        int unsigned wait_left;
        logic        took;
        wait_left = 0;
        forever begin
            @(posedge aclk);
            took = m_tvalid && m_tready;
            @(negedge aclk);
            if (hold_req > 0) begin
                wait_left = hold_req;
                hold_req  = 0;
            end else if (took) begin
                wait_left = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (wait_left > 0) begin
                m_tready <= 1'b0;
                wait_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frames_due.size() == 0) begin
                flag_mismatch("reply with none expected", m_tdata, 32'd0);
            end else begin
                want = frames_due.pop_front();
                if (m_tdata[7:0] !== want.servo_id)
                    flag_mismatch("servo_id", 32'(m_tdata[7:0]), 32'(want.servo_id));
                if (m_tdata[15:8] !== want.reg_addr)
                    flag_mismatch("reg_addr", 32'(m_tdata[15:8]), 32'(want.reg_addr));
                if (m_tdata[31:16] !== want.reg_value)
                    flag_mismatch("reg_value", 32'(m_tdata[31:16]), 32'(want.reg_value));
                if (m_tuser[0] !== want.in_range)
                    flag_mismatch("in_range", 32'(m_tuser[0]), 32'(want.in_range));
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_frames();
        test_config_limits();
        test_output_backpressure();
        test_random_stream();

        settle_idle();
        if (frames_due.size() != 0)
            flag_mismatch("replies never delivered", 32'(frames_due.size()), 32'd0);
        if (mismatch_count == 0) begin
            $display("servo_reply_frame_parser verification clean");
        end else begin
            $display("servo_reply_frame_parser verification failed");
        end
        $finish;
    end

endmodule
